// ----- design/assert_macros.svh -----
// Assertion macros shared by the engine's modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// The expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER_CLK(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER_CLK(lbl, clk, rstn, expr)
`endif
`endif

// ----- design/hsha_pkg.sv -----
package hsha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        key_flag;
    logic        segment_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_START_PAD,
    OP_HASH_BYTE,
    OP_KEY_BYTE,
    OP_KEY_CLEAR,
    OP_KEY_FROM_CHAIN,
    OP_SAVE_INNER,
    OP_FIN_START
  } op_e;

  typedef enum logic [2:0] {
    BS_DATA,
    BS_MARK,
    BS_ZERO,
    BS_LEN,
    BS_INNER
  } bsrc_e;

  typedef enum logic [1:0] {
    PAD_NONE,
    PAD_IN,
    PAD_OUT
  } pad_e;

  typedef struct packed {
    op_e        op;
    bsrc_e      bsrc;
    pad_e       pad;
    logic [4:0] idx;
    logic       load_word;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic pos_at_len;
    logic key_full;
  } status_t;

  localparam logic [31:0] SHA_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  IPAD = 8'h36;
  localparam logic [7:0]  OPAD = 8'h5c;
  localparam logic [7:0]  PAD_MARK = 8'h80;
  // 448 bits into the block is byte 56, where the length field starts.
  localparam logic [5:0]  LEN_POS = 6'd56;
  localparam logic [6:0]  LAST_ROUND = 7'd80;
  localparam logic [6:0]  KEY_BLOCK_BYTES = 7'd64;

endpackage

// ----- design/hsha_dp.sv -----
module hsha_dp import hsha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] word_i,
  output status_t     stat_o,
  output logic [31:0] digest_o
);

`include "assert_macros.svh"

  logic [31:0] chain_q [5];
  logic [31:0] chain_d [5];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [31:0] key_q [16];
  logic [31:0] key_d [16];
  logic [31:0] inner_q [5];
  logic [31:0] inner_d [5];
  logic [63:0] bitlen_q, bitlen_d, len_q, len_d;
  logic [6:0]  kcnt_q, kcnt_d, round_q, round_d;
  logic        busy_q, busy_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q, a_d, b_d, c_d, d_d, e_d;
  logic [31:0] word_q, word_d;

  logic [5:0]  pos;
  logic [1:0]  db, ib, kb;
  logic [2:0]  lb;
  logic [7:0]  byte_v, pad_byte;
  logic [31:0] f, k, tmp, wnew;

  always_comb begin
    db = 2'd3 - cmd_i.idx[1:0];
    ib = 2'd3 - cmd_i.idx[1:0];
    lb = 3'd7 - cmd_i.idx[2:0];
    case (cmd_i.bsrc)
      BS_DATA:  byte_v = word_q[{db, 3'b000} +: 8];
      BS_MARK:  byte_v = PAD_MARK;
      BS_LEN:   byte_v = len_q[{lb, 3'b000} +: 8];
      BS_INNER: byte_v = inner_q[cmd_i.idx[4:2]][{ib, 3'b000} +: 8];
      default:  byte_v = 8'h00;
    endcase
    case (cmd_i.pad)
      PAD_IN:  pad_byte = IPAD;
      PAD_OUT: pad_byte = OPAD;
      default: pad_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (round_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = K0;
    end else if (round_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (round_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    tmp  = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
    wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wnew[30:0], wnew[31]};
  end

  assign pos = bitlen_q[8:3];
  assign kb  = 2'd3 - kcnt_q[1:0];

  always_comb begin
    chain_d  = chain_q;
    w_d      = w_q;
    key_d    = key_q;
    inner_d  = inner_q;
    bitlen_d = bitlen_q;
    len_d    = len_q;
    kcnt_d   = kcnt_q;
    round_d  = round_q;
    busy_d   = busy_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    word_d   = cmd_i.load_word ? word_i : word_q;
    if (busy_q) begin
      if (round_q == LAST_ROUND) begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        busy_d = 1'b0;
      end else begin
        a_d = tmp;
        b_d = a_q;
        c_d = {b_q[1:0], b_q[31:2]};
        d_d = c_q;
        e_d = d_q;
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wnew;
        round_d = round_q + 7'd1;
      end
    end else begin
      case (cmd_i.op)
        OP_INIT: begin
          chain_d  = SHA_INIT;
          bitlen_d = '0;
        end
        OP_START_PAD: begin
          chain_d = SHA_INIT;
          for (int i = 0; i < 16; i++) w_d[i] = key_q[i] ^ {4{pad_byte}};
          bitlen_d = 64'd512;
          a_d = SHA_INIT[0]; b_d = SHA_INIT[1]; c_d = SHA_INIT[2];
          d_d = SHA_INIT[3]; e_d = SHA_INIT[4];
          round_d = '0;
          busy_d  = 1'b1;
        end
        OP_HASH_BYTE: begin
          w_d[pos[5:2]] = ((pos[1:0] == 2'd0) ? 32'h0 : w_q[pos[5:2]]) |
                          ({24'h0, byte_v} << {2'd3 - pos[1:0], 3'b000});
          bitlen_d = bitlen_q + 64'd8;
          if (pos == 6'd63) begin
            a_d = chain_q[0]; b_d = chain_q[1]; c_d = chain_q[2];
            d_d = chain_q[3]; e_d = chain_q[4];
            round_d = '0;
            busy_d  = 1'b1;
          end
        end
        OP_KEY_BYTE: begin
          key_d[kcnt_q[5:2]] = key_q[kcnt_q[5:2]] | ({24'h0, byte_v} << {kb, 3'b000});
          kcnt_d = kcnt_q + 7'd1;
        end
        OP_KEY_CLEAR: begin
          for (int i = 0; i < 16; i++) key_d[i] = '0;
          kcnt_d = '0;
        end
        OP_KEY_FROM_CHAIN: begin
          for (int i = 0; i < 16; i++) key_d[i] = (i < 5) ? chain_q[i % 5] : 32'h0;
        end
        OP_SAVE_INNER: inner_d = chain_q;
        OP_FIN_START:  len_d = bitlen_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q  <= SHA_INIT;
      for (int i = 0; i < 16; i++) key_q[i] <= '0;
      bitlen_q <= '0;
      kcnt_q   <= '0;
      round_q  <= '0;
      busy_q   <= 1'b0;
    end else begin
      chain_q  <= chain_d;
      key_q    <= key_d;
      bitlen_q <= bitlen_d;
      kcnt_q   <= kcnt_d;
      round_q  <= round_d;
      busy_q   <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    inner_q <= inner_d;
    len_q   <= len_d;
    word_q  <= word_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
  end

  assign stat_o.busy       = busy_q;
  assign stat_o.pos_at_len = (pos == LEN_POS);
  assign stat_o.key_full   = (kcnt_q == KEY_BLOCK_BYTES);
  assign digest_o          = chain_q[cmd_i.out_idx];

  `ASSERT_CLK(a_round_range, clk_i, rst_ni, busy_q |-> round_q <= LAST_ROUND)
  `ASSERT_CLK(a_key_count, clk_i, rst_ni, kcnt_q <= KEY_BLOCK_BYTES)
  `ASSERT_CLK(a_busy_ends, clk_i, rst_ni,
              (busy_q && round_q == LAST_ROUND) |=> !busy_q)

endmodule

// ----- design/hsha_ctrl.sv -----
module hsha_ctrl import hsha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  in_item_t   in_data_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] word_index_o,
  output logic       last_word_o,
  input  status_t    stat_i,
  output cmd_t       cmd_o
);

`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_KBYTE = 4'd2;
  localparam logic [3:0] S_CLOSE = 4'd3;
  localparam logic [3:0] S_KFROM = 4'd4;
  localparam logic [3:0] S_KDONE = 4'd5;
  localparam logic [3:0] S_MSTRT = 4'd6;
  localparam logic [3:0] S_MBYTE = 4'd7;
  localparam logic [3:0] S_FSTRT = 4'd8;
  localparam logic [3:0] S_FMARK = 4'd9;
  localparam logic [3:0] S_FZERO = 4'd10;
  localparam logic [3:0] S_FLEN  = 4'd11;
  localparam logic [3:0] S_AFTER = 4'd12;
  localparam logic [3:0] S_OSTRT = 4'd13;
  localparam logic [3:0] S_OBYTE = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_KEY   = 3'd1;
  localparam logic [2:0] PH_PLAIN = 3'd2;
  localparam logic [2:0] PH_HIN   = 3'd3;
  localparam logic [2:0] PH_HOUT  = 3'd4;

  localparam logic [2:0] LAST_IDX = 3'd4;

  logic [3:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic [4:0] ctr_q, ctr_d;
  logic [2:0] cnt_q, cnt_d, oidx_q, oidx_d;
  logic       key_q, key_d, end_q, end_d, long_q, long_d, hmac_q;
  logic       in_acc;

  assign in_stall_o   = !((state_q == S_IDLE) && !stat_i.busy);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = oidx_q;
  assign last_word_o  = (oidx_q == LAST_IDX);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    ctr_d   = ctr_q;
    cnt_d   = cnt_q;
    oidx_d  = oidx_q;
    key_d   = key_q;
    end_d   = end_q;
    long_d  = long_q;
    cmd_o   = '{op: OP_NONE, bsrc: BS_DATA, pad: PAD_NONE, idx: ctr_q,
                load_word: in_acc, out_idx: oidx_q};
    if (in_acc) begin
      cnt_d   = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;
      key_d   = in_data_i.key_flag;
      end_d   = in_data_i.segment_end;
      state_d = S_DISP;
    end
    if (!stat_i.busy) begin
      unique case (state_q)
        S_IDLE: ;
        S_DISP: begin
          ctr_d = '0;
          if (key_q) begin
            if (!hmac_q || phase_q == PH_PLAIN || phase_q == PH_HIN) begin
              state_d = S_IDLE;
            end else begin
              if (phase_q == PH_IDLE) begin
                cmd_o.op = OP_KEY_CLEAR;
                long_d   = 1'b0;
                phase_d  = PH_KEY;
              end
              state_d = S_KBYTE;
            end
          end else if (phase_q == PH_KEY) begin
            state_d = S_CLOSE;
          end else if (phase_q == PH_IDLE) begin
            state_d = S_MSTRT;
          end else begin
            state_d = S_MBYTE;
          end
        end
        S_KBYTE: begin
          if (ctr_q < {2'b00, cnt_q}) begin
            if (!long_q && !stat_i.key_full) begin
              cmd_o.op = OP_KEY_BYTE;
              ctr_d    = ctr_q + 5'd1;
            end else if (!long_q) begin
              cmd_o.op  = OP_START_PAD;
              cmd_o.pad = PAD_NONE;
              long_d    = 1'b1;
            end else begin
              cmd_o.op = OP_HASH_BYTE;
              ctr_d    = ctr_q + 5'd1;
            end
          end else begin
            state_d = end_q ? S_CLOSE : S_IDLE;
          end
        end
        S_CLOSE: state_d = long_q ? S_FSTRT : S_KDONE;
        S_KFROM: begin
          cmd_o.op = OP_KEY_FROM_CHAIN;
          state_d  = S_KDONE;
        end
        S_KDONE: begin
          long_d  = 1'b0;
          phase_d = PH_IDLE;
          state_d = key_q ? S_IDLE : S_DISP;
        end
        S_MSTRT: begin
          if (hmac_q) begin
            cmd_o.op  = OP_START_PAD;
            cmd_o.pad = PAD_IN;
            phase_d   = PH_HIN;
          end else begin
            cmd_o.op = OP_INIT;
            phase_d  = PH_PLAIN;
          end
          ctr_d   = '0;
          state_d = S_MBYTE;
        end
        S_MBYTE: begin
          if (ctr_q < {2'b00, cnt_q}) begin
            cmd_o.op = OP_HASH_BYTE;
            ctr_d    = ctr_q + 5'd1;
          end else begin
            state_d = end_q ? S_FSTRT : S_IDLE;
          end
        end
        S_FSTRT: begin
          cmd_o.op = OP_FIN_START;
          state_d  = S_FMARK;
        end
        S_FMARK: begin
          cmd_o.op   = OP_HASH_BYTE;
          cmd_o.bsrc = BS_MARK;
          state_d    = S_FZERO;
        end
        S_FZERO: begin
          if (!stat_i.pos_at_len) begin
            cmd_o.op   = OP_HASH_BYTE;
            cmd_o.bsrc = BS_ZERO;
          end else begin
            ctr_d   = '0;
            state_d = S_FLEN;
          end
        end
        S_FLEN: begin
          cmd_o.op   = OP_HASH_BYTE;
          cmd_o.bsrc = BS_LEN;
          ctr_d      = ctr_q + 5'd1;
          if (ctr_q == 5'd7) state_d = S_AFTER;
        end
        S_AFTER: begin
          if (phase_q == PH_KEY) begin
            state_d = S_KFROM;
          end else if (phase_q == PH_HIN) begin
            cmd_o.op = OP_SAVE_INNER;
            state_d  = S_OSTRT;
          end else begin
            oidx_d  = '0;
            state_d = S_OUT;
          end
        end
        S_OSTRT: begin
          cmd_o.op  = OP_START_PAD;
          cmd_o.pad = PAD_OUT;
          phase_d   = PH_HOUT;
          ctr_d     = '0;
          state_d   = S_OBYTE;
        end
        S_OBYTE: begin
          cmd_o.op   = OP_HASH_BYTE;
          cmd_o.bsrc = BS_INNER;
          ctr_d      = ctr_q + 5'd1;
          if (ctr_q == 5'd19) state_d = S_FSTRT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            if (oidx_q == LAST_IDX) begin
              phase_d = PH_IDLE;
              state_d = S_IDLE;
            end else begin
              oidx_d = oidx_q + 3'd1;
            end
          end
        end
        default: state_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_IDLE;
      ctr_q   <= '0;
      oidx_q  <= '0;
      long_q  <= 1'b0;
      hmac_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ctr_q   <= ctr_d;
      oidx_q  <= oidx_d;
      long_q  <= long_d;
      if (cfg_we_i) hmac_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    key_q <= key_d;
    end_q <= end_d;
  end

  `ASSERT_CLK(a_cmd_when_free, clk_i, rst_ni, (cmd_o.op != OP_NONE) |-> !stat_i.busy)
  `ASSERT_NEVER_CLK(a_out_busy, clk_i, rst_ni, out_valid_o && stat_i.busy)
  `ASSERT_CLK(a_ready_after_last, clk_i, rst_ni,
              (out_valid_o && !out_stall_i && last_word_o) |=> !in_stall_o)

endmodule

// ----- design/hmac_sha1_engine.sv -----
// Streaming SHA-1 and HMAC-SHA1 engine.
// Input channel: in_valid_i / in_stall_o carry one request per word: a
// big-endian data word, its count of valid bytes, a key flag and an end of
// segment mark. In HMAC mode a key segment precedes the message. The user
// must have cfg_we_i write cfg_wdata_i into the mode bit only while the
// engine is idle; the engine itself does not enforce this.
// Output channel: after a message end, five digest requests are offered on
// out_valid_o / out_stall_i, most significant word first, the fifth marked
// last. While the receiver stalls, the word on offer holds still and the
// engine takes no new input.
// Sequence: the engine takes one request at a time. Each word is handled
// by acceptance, dispatch, a byte-loop step per valid byte and the end of
// its byte loop, and every filled 64-byte block goes through the compression
// unit (80 rounds and the chain update). Finishing a message adds the
// padding bytes and one or two further compressions, plus the whole outer
// hash in HMAC mode.
// Reset returns the mode to plain SHA-1, empties the key and idles the engine.
module hmac_sha1_engine import hsha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  input  in_item_t  in_data_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // The controller sequences bytes, padding and the HMAC passes; the
  // datapath holds the block buffer, chain, key and compression unit.
  cmd_t        cmd;
  status_t     stat;
  logic [31:0] digest;
  logic [2:0]  word_index;
  logic        last_word;

  hsha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index),
    .last_word_o  (last_word),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  hsha_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .word_i   (in_data_i.data_word),
    .stat_o   (stat),
    .digest_o (digest)
  );

  // The digest word is read straight from the chain registers, which stay
  // put while the words are on offer.
  assign out_data_o.digest_word = digest;
  assign out_data_o.word_index  = word_index;
  assign out_data_o.last_word   = last_word;

endmodule
